// ----- rtl/dvd_pkg.sv -----
// Shared types, codes and constants for the dense vector distance unit.
// No dependencies; imported by dvd_divider and dense_vector_distance_unit.
package dvd_pkg;

   localparam int INPUT_WIDTH = 32;
   localparam int LOG_FRAC    = 24;
   localparam int DIV_STEPS   = 48;
   localparam int EXP_STEPS   = 24;

   localparam logic [2:0] MET_EUCLID    = 3'd0;
   localparam logic [2:0] MET_MAXIMUM   = 3'd1;
   localparam logic [2:0] MET_MANHATTAN = 3'd2;
   localparam logic [2:0] MET_MINKOWSKI = 3'd3;
   localparam logic [2:0] MET_CANBERRA  = 3'd4;

   localparam logic CSR_METRIC = 1'b0;
   localparam logic CSR_MINK_P = 1'b1;

   localparam logic [15:0] P_RESET = 16'd512;
   localparam logic [15:0] P_MIN   = 16'd256;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] DIST_MAX = 64'h0000_FFFF_FFFF_FFFF;

   // log-domain offsets and limits, Q.24
   localparam logic [30:0] LOG_OFS_16 = 31'(16 << LOG_FRAC);
   localparam logic [30:0] LOG_OFS_32 = 31'(32 << LOG_FRAC);
   localparam logic [39:0] EXP_LIM_48 = 40'(48 << LOG_FRAC);
   localparam logic [39:0] EXP_LIM_64 = 40'(64 << LOG_FRAC);
   localparam logic [39:0] EXP_BASE_16 = 40'(16 << LOG_FRAC);
   localparam logic [39:0] EXP_BASE_32 = 40'(32 << LOG_FRAC);

   typedef logic [EXP_STEPS-1:0][31:0] root_tab_type;

   function automatic logic [63:0] isqrt_c(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bt;
      rem = v;
      res = '0;
      bt  = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bt) begin
            rem = rem - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // successive roots of two in Q1.31: entry i holds 2^(2^-(i+1))
   function automatic root_tab_type root_table();
      root_tab_type tab;
      logic [63:0]  r;
      r = 64'd1 << 32;
      for (int i = 0; i < EXP_STEPS; i++) begin
         r      = isqrt_c(r << 31);
         tab[i] = r[31:0];
      end
      return tab;
   endfunction

   localparam root_tab_type ROOT_TAB = root_table();

endpackage

// ----- rtl/dvd_divider.sv -----
// Restoring divider, one quotient bit per cycle, 48-bit dividend, 33-bit divisor.
// Depends on dvd_pkg for the step count.
module dvd_divider
   import dvd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [47:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] num_ff, num_in;
   logic [32:0] den_ff, den_in;
   logic [32:0] rem_ff, rem_in;
   logic [33:0] trial;
   logic [33:0] diff;
   logic        ge;

   assign trial = {rem_ff, num_ff[47]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift quotient bits into the freed low end of the dividend
         rem_in = ge ? diff[32:0] : trial[32:0];
         num_in = {num_ff[46:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

// ----- rtl/dense_vector_distance_unit.sv -----
// Dense vector distance unit: one element pair a beat, distance on the last pair.
// Per pair: maximum and manhattan fold on accept, euclidean squares, canberra divides,
// minkowski runs 6 normalize steps, 24 log squarings and up to
// 24 exp products on the shared 32x32 multiplier; a last pair adds
// the euclidean root, or the minkowski root on the divider.
// One pair in flight at a time. Synchronous active-high reset clears control and accumulator.
module dense_vector_distance_unit
   import dvd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_x_value,
   input  logic [31:0] req_y_value,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [47:0] rsp_distance,
   output logic        rsp_saturated,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_SQ_MUL   = 5'd1;
   localparam logic [4:0] ST_SQ_ADD   = 5'd2;
   localparam logic [4:0] ST_CB_WAIT  = 5'd3;
   localparam logic [4:0] ST_NORM     = 5'd4;
   localparam logic [4:0] ST_LOG_MUL  = 5'd5;
   localparam logic [4:0] ST_LOG_USE  = 5'd6;
   localparam logic [4:0] ST_TM_MUL   = 5'd7;
   localparam logic [4:0] ST_TM_E     = 5'd8;
   localparam logic [4:0] ST_RT_DIV   = 5'd9;
   localparam logic [4:0] ST_RT_WAIT  = 5'd10;
   localparam logic [4:0] ST_EX_STEP  = 5'd11;
   localparam logic [4:0] ST_EX_USE   = 5'd12;
   localparam logic [4:0] ST_EX_SHIFT = 5'd13;
   localparam logic [4:0] ST_FIN      = 5'd14;
   localparam logic [4:0] ST_SQRT     = 5'd15;
   localparam logic [4:0] ST_EMIT     = 5'd16;

   logic [2:0]  metric_ff;
   logic [15:0] p_ff;
   logic [15:0] p_eff;

   logic [4:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic [31:0] ad_ff, ad_in;
   logic        last_ff, last_in;
   logic        root_ff, root_in;
   logic [63:0] nv_ff, nv_in;
   logic [5:0]  lz_ff, lz_in;
   logic [31:0] lm_ff, lm_in;
   logic [5:0]  n_ff, n_in;
   logic [23:0] frac_ff, frac_in;
   logic [31:0] em_ff, em_in;
   logic [5:0]  ek_ff, ek_in;
   logic [23:0] ef_ff, ef_in;
   logic [63:0] sres_ff, sres_in;
   logic [63:0] sv_ff, sv_in;
   logic [63:0] dist_ff, dist_in;
   logic        clip_ff, clip_in;
   logic [63:0] mul_p_ff;
   logic [31:0] mul_a, mul_b;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_dist_ff, rsp_dist_in;
   logic        rsp_sat_ff, rsp_sat_in;

   // input decode
   logic        accept;
   logic [32:0] xs, ys, dv, axs, ays;
   logic [31:0] ad_req;
   logic [32:0] den_req;

   // shared arithmetic
   logic [63:0] add_b, add_cap;
   logic [64:0] add_sum;
   logic        add_ovf;
   logic [63:0] add_res;
   logic [29:0] logv;
   logic [30:0] logd;
   logic        lneg;
   logic [29:0] lmag;
   logic [37:0] e_op;
   logic [39:0] e_base, e_lim, e_val;
   logic        e_neg, e_big;
   logic [32:0] lsq;
   logic [63:0] er;
   logic [63:0] sq_bit, sq_rb;
   logic [5:0]  sq_sh;

   // divider hookup
   logic        div_start;
   logic [47:0] div_dividend;
   logic [32:0] div_divisor;
   logic        div_done;
   logic [47:0] div_quot;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   assign p_eff = (p_ff < P_MIN) ? P_MIN : p_ff;

   assign xs      = 33'(signed'(req_x_value[INPUT_WIDTH-1:0]));
   assign ys      = 33'(signed'(req_y_value[INPUT_WIDTH-1:0]));
   assign dv      = xs - ys;
   assign ad_req  = dv[32] ? 32'(-dv) : dv[31:0];
   assign axs     = xs[32] ? -xs : xs;
   assign ays     = ys[32] ? -ys : ys;
   assign den_req = axs + ays;

   // saturating accumulate: add_b and add_cap are picked by the sequencer
   assign add_sum = {1'b0, acc_ff} + {1'b0, add_b};
   assign add_ovf = (acc_ff > add_cap) || (add_sum > {1'b0, add_cap});
   assign add_res = add_ovf ? add_cap : add_sum[63:0];

   // log result in Q.24 less the format offset, as sign and magnitude
   assign logv = {n_ff, frac_ff};
   assign logd = {1'b0, logv} - (root_ff ? LOG_OFS_32 : LOG_OFS_16);
   assign lneg = logd[30];
   assign lmag = lneg ? 30'(-logd) : logd[29:0];

   // exponent argument from the scaled log
   assign e_op   = (state_ff == ST_TM_E) ? mul_p_ff[45:8] : div_quot[37:0];
   assign e_base = root_ff ? EXP_BASE_16 : EXP_BASE_32;
   assign e_lim  = root_ff ? EXP_LIM_48 : EXP_LIM_64;
   assign e_val  = lneg ? (e_base - {2'b0, e_op}) : (e_base + {2'b0, e_op});
   assign e_neg  = e_val[39];
   assign e_big  = !e_neg && (e_val >= e_lim);

   assign lsq = mul_p_ff[63:31];

   assign er = (ek_ff >= 6'd31) ? ({32'b0, em_ff} << (ek_ff - 6'd31))
                                : ({32'b0, em_ff} >> (6'd31 - ek_ff));

   assign sq_sh  = 6'd62 - {cnt_ff, 1'b0};
   assign sq_bit = 64'd1 << sq_sh;
   assign sq_rb  = sres_ff + sq_bit;

   assign div_start    = (accept && metric_ff == MET_CANBERRA && den_req != '0)
                         || (state_ff == ST_RT_DIV);
   assign div_dividend = (state_ff == ST_RT_DIV) ? {10'b0, lmag, 8'b0} : {ad_req, 16'b0};
   assign div_divisor  = (state_ff == ST_RT_DIV) ? {17'b0, p_eff} : den_req;

   dvd_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_SQ_MUL: begin
            mul_a = ad_ff;
            mul_b = ad_ff;
         end
         ST_LOG_MUL: begin
            mul_a = lm_ff;
            mul_b = lm_ff;
         end
         ST_TM_MUL: begin
            mul_a = {2'b0, lmag};
            mul_b = {16'b0, p_eff};
         end
         ST_EX_STEP: begin
            mul_a = em_ff;
            mul_b = ROOT_TAB[cnt_ff];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // accumulate operand select
   always_comb begin
      add_b   = '0;
      add_cap = ALL_ONES;
      case (state_ff)
         ST_IDLE: begin
            add_b   = {32'b0, ad_req};
            add_cap = DIST_MAX;
         end
         ST_SQ_ADD: begin
            add_b = mul_p_ff;
         end
         ST_CB_WAIT: begin
            add_b   = {16'b0, div_quot};
            add_cap = DIST_MAX;
         end
         ST_EX_SHIFT: begin
            add_b = er;
         end
         default: begin
            add_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      ad_in        = ad_ff;
      last_in      = last_ff;
      root_in      = root_ff;
      nv_in        = nv_ff;
      lz_in        = lz_ff;
      lm_in        = lm_ff;
      n_in         = n_ff;
      frac_in      = frac_ff;
      em_in        = em_ff;
      ek_in        = ek_ff;
      ef_in        = ef_ff;
      sres_in      = sres_ff;
      sv_in        = sv_ff;
      dist_in      = dist_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_sat_in   = rsp_sat_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ad_in   = ad_req;
               last_in = req_last_element;
               root_in = 1'b0;
               state_in = ST_FIN;
               case (metric_ff)
                  MET_EUCLID: begin
                     state_in = ST_SQ_MUL;
                  end
                  MET_MAXIMUM: begin
                     if ({32'b0, ad_req} > acc_ff) begin
                        acc_in = {32'b0, ad_req};
                     end
                  end
                  MET_MANHATTAN: begin
                     acc_in = add_res;
                     ovf_in = ovf_ff || add_ovf;
                  end
                  MET_MINKOWSKI: begin
                     if (ad_req != '0) begin
                        nv_in    = {32'b0, ad_req};
                        lz_in    = '0;
                        cnt_in   = '0;
                        state_in = ST_NORM;
                     end
                  end
                  MET_CANBERRA: begin
                     if (den_req != '0) begin
                        state_in = ST_CB_WAIT;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_SQ_MUL: begin
            state_in = ST_SQ_ADD;
         end
         ST_SQ_ADD: begin
            acc_in   = add_res;
            ovf_in   = ovf_ff || add_ovf;
            state_in = ST_FIN;
         end
         ST_CB_WAIT: begin
            if (div_done) begin
               acc_in   = add_res;
               ovf_in   = ovf_ff || add_ovf;
               state_in = ST_FIN;
            end
         end
         ST_NORM: begin
            // binary search for the leading one
            case (cnt_ff)
               5'd0: if (nv_ff[63:32] == '0) begin
                  nv_in = nv_ff << 32;
                  lz_in = lz_ff + 6'd32;
               end
               5'd1: if (nv_ff[63:48] == '0) begin
                  nv_in = nv_ff << 16;
                  lz_in = lz_ff + 6'd16;
               end
               5'd2: if (nv_ff[63:56] == '0) begin
                  nv_in = nv_ff << 8;
                  lz_in = lz_ff + 6'd8;
               end
               5'd3: if (nv_ff[63:60] == '0) begin
                  nv_in = nv_ff << 4;
                  lz_in = lz_ff + 6'd4;
               end
               5'd4: if (nv_ff[63:62] == '0) begin
                  nv_in = nv_ff << 2;
                  lz_in = lz_ff + 6'd2;
               end
               default: if (!nv_ff[63]) begin
                  nv_in = nv_ff << 1;
                  lz_in = lz_ff + 6'd1;
               end
            endcase
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd5) begin
               lm_in    = nv_in[63:32];
               n_in     = 6'd63 - lz_in;
               frac_in  = '0;
               cnt_in   = '0;
               state_in = ST_LOG_MUL;
            end
         end
         ST_LOG_MUL: begin
            state_in = ST_LOG_USE;
         end
         ST_LOG_USE: begin
            frac_in = {frac_ff[22:0], lsq[32]};
            lm_in   = lsq[32] ? lsq[32:1] : lsq[31:0];
            cnt_in  = cnt_ff + 5'd1;
            state_in = ST_LOG_MUL;
            if (cnt_ff == 5'(LOG_FRAC - 1)) begin
               state_in = root_ff ? ST_RT_DIV : ST_TM_MUL;
            end
         end
         ST_TM_MUL: begin
            state_in = ST_TM_E;
         end
         ST_RT_DIV: begin
            state_in = ST_RT_WAIT;
         end
         ST_TM_E, ST_RT_WAIT: begin
            if (state_ff == ST_TM_E || div_done) begin
               if (e_neg) begin
                  // term or root below one unit
                  dist_in  = '0;
                  state_in = root_ff ? ST_EMIT : ST_FIN;
               end else if (e_big) begin
                  if (root_ff) begin
                     clip_in  = 1'b1;
                     dist_in  = DIST_MAX;
                     state_in = ST_EMIT;
                  end else begin
                     acc_in   = ALL_ONES;
                     ovf_in   = 1'b1;
                     state_in = ST_FIN;
                  end
               end else begin
                  ek_in    = e_val[29:24];
                  ef_in    = e_val[23:0];
                  em_in    = 32'h8000_0000;
                  cnt_in   = '0;
                  state_in = ST_EX_STEP;
               end
            end
         end
         ST_EX_STEP: begin
            if (ef_ff[23]) begin
               state_in = ST_EX_USE;
            end else begin
               ef_in  = ef_ff << 1;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'(EXP_STEPS - 1)) begin
                  state_in = ST_EX_SHIFT;
               end
            end
         end
         ST_EX_USE: begin
            em_in  = mul_p_ff[62:31];
            ef_in  = ef_ff << 1;
            cnt_in = cnt_ff + 5'd1;
            state_in = (cnt_ff == 5'(EXP_STEPS - 1)) ? ST_EX_SHIFT : ST_EX_STEP;
         end
         ST_EX_SHIFT: begin
            if (root_ff) begin
               dist_in  = er;
               state_in = ST_EMIT;
            end else begin
               acc_in   = add_res;
               ovf_in   = ovf_ff || add_ovf;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            clip_in = 1'b0;
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
               case (metric_ff)
                  MET_EUCLID: begin
                     sv_in    = acc_ff;
                     sres_in  = '0;
                     cnt_in   = '0;
                     state_in = ST_SQRT;
                  end
                  MET_MAXIMUM, MET_MANHATTAN, MET_CANBERRA: begin
                     dist_in = acc_ff;
                  end
                  MET_MINKOWSKI: begin
                     if (acc_ff == '0) begin
                        dist_in = '0;
                     end else begin
                        nv_in    = acc_ff;
                        lz_in    = '0;
                        cnt_in   = '0;
                        root_in  = 1'b1;
                        state_in = ST_NORM;
                     end
                  end
                  default: begin
                     dist_in = '0;
                  end
               endcase
            end
         end
         ST_SQRT: begin
            if (sv_ff >= sq_rb) begin
               sv_in   = sv_ff - sq_rb;
               sres_in = (sres_ff >> 1) + sq_bit;
            end else begin
               sres_in = sres_ff >> 1;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               dist_in  = sres_in;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = (dist_ff > DIST_MAX) ? DIST_MAX[47:0] : dist_ff[47:0];
               rsp_sat_in   = ovf_ff || clip_ff || (dist_ff > DIST_MAX);
               acc_in       = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff    <= MET_EUCLID;
         p_ff         <= P_RESET;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         root_ff      <= 1'b0;
         last_ff      <= 1'b0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_METRIC) begin
               metric_ff <= csr_write_data[2:0];
            end else begin
               p_ff <= csr_write_data;
            end
         end
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         root_ff      <= root_in;
         last_ff      <= last_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ad_ff       <= ad_in;
      nv_ff       <= nv_in;
      lz_ff       <= lz_in;
      lm_ff       <= lm_in;
      n_ff        <= n_in;
      frac_ff     <= frac_in;
      em_ff       <= em_in;
      ek_ff       <= ek_in;
      ef_ff       <= ef_in;
      sres_ff     <= sres_in;
      sv_ff       <= sv_in;
      dist_ff     <= dist_in;
      mul_p_ff    <= {32'b0, mul_a} * {32'b0, mul_b};
      rsp_dist_ff <= rsp_dist_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

// ----- bench/tb_dense_vector_distance_unit.sv -----
// Self-checking bench for dense_vector_distance_unit: pair beats in, distances out,
// checked against a fixed-point distance predictor kept inside the bench.
// Depends on dvd_pkg and the dense_vector_distance_unit RTL.
`timescale 1ns / 100ps

module tb_dense_vector_distance_unit;
   import dvd_pkg::*;

   localparam logic [2:0] MET_SPARE_LO = 3'd5;
   localparam logic [2:0] MET_SPARE_HI = 3'd7;
   localparam int         SETTLE_CYCLES = 300;
   localparam int         TARGET_PAIRS  = 1050;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic        last;
   } pair_beat_type;

   typedef struct packed {
      logic [47:0] distance;
      logic        saturated;
   } distance_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_x_value = '0;
   logic [31:0] req_y_value = '0;
   logic        req_last_element = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [47:0] rsp_distance;
   logic        rsp_saturated;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_METRIC;
   logic [15:0] csr_write_data = '0;

   dense_vector_distance_unit DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- distance predictor ----------------
   logic [2:0]  metric_cfg = MET_EUCLID;
   logic [15:0] exponent_cfg = P_RESET;
   logic [63:0] running_sum = '0;
   logic        clip_seen = 1'b0;

   pair_beat_type pending_pairs[$];
   distance_type  expected_distances[$];
   int          errors = 0;
   int          pairs_sent = 0;
   int          distances_seen = 0;

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bt;
      res = '0;
      bt  = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic longint log2_q24(logic [63:0] v);
      int          n;
      logic [63:0] m, frac;
      n    = 63;
      frac = '0;
      while (n > 0 && !v[n]) n--;
      m = (n >= 31) ? (v >> (n - 31)) : (v << (31 - n));
      for (int i = 0; i < LOG_FRAC; i++) begin
         m    = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            m       = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return (longint'(n) << LOG_FRAC) | longint'(frac);
   endfunction

   function automatic logic [63:0] exp2_q24(logic [63:0] e);
      int          k;
      logic [63:0] f, m, r;
      k = int'(e >> LOG_FRAC);
      f = e & ((64'd1 << LOG_FRAC) - 1);
      m = 64'd1 << 31;
      r = 64'd1 << 32;
      for (int i = 1; i <= LOG_FRAC; i++) begin
         r = int_sqrt(r << 31);
         if (f[LOG_FRAC - i]) m = (m * r) >> 31;
      end
      if (k >= 31) return m << (k - 31);
      return m >> (31 - k);
   endfunction

   function automatic longint exponent_eff();
      return (exponent_cfg < P_MIN) ? longint'(P_MIN) : longint'(exponent_cfg);
   endfunction

   function automatic logic [63:0] clipped_add(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] cap);
      if (a > cap || b > cap - a) begin
         clip_seen = 1'b1;
         return cap;
      end
      return a + b;
   endfunction

   function automatic logic [63:0] power_term(logic [63:0] ad);
      longint t, e;
      if (ad == 0) return '0;
      t = ((log2_q24(ad) - (longint'(16) << LOG_FRAC)) * exponent_eff()) / 256;
      e = t + (longint'(32) << LOG_FRAC);
      if (e < 0) return '0;
      if (e >= (longint'(64) << LOG_FRAC)) begin
         clip_seen = 1'b1;
         return ALL_ONES;
      end
      return exp2_q24(64'(e));
   endfunction

   function automatic logic [63:0] power_root(logic [63:0] sum, ref logic clip);
      longint      q, e;
      logic [63:0] r;
      if (sum == 0) return '0;
      q = ((log2_q24(sum) - (longint'(32) << LOG_FRAC)) * 256) / exponent_eff();
      e = q + (longint'(16) << LOG_FRAC);
      if (e < 0) return '0;
      if (e >= (longint'(48) << LOG_FRAC)) begin
         clip = 1'b1;
         return DIST_MAX;
      end
      r = exp2_q24(64'(e));
      if (r > DIST_MAX) begin
         clip = 1'b1;
         r    = DIST_MAX;
      end
      return r;
   endfunction

   // fold one accepted pair; queue a distance on the last pair
   function automatic void fold_pair(pair_beat_type b);
      longint       x, y, d;
      logic [63:0]  ad, ax, ay, dist_value;
      logic         clip;
      distance_type res;
      x    = longint'(signed'(b.x));
      y    = longint'(signed'(b.y));
      d    = x - y;
      ad   = 64'(d < 0 ? -d : d);
      ax   = 64'(x < 0 ? -x : x);
      ay   = 64'(y < 0 ? -y : y);
      clip = 1'b0;
      dist_value = '0;
      case (metric_cfg)
         MET_EUCLID:    running_sum = clipped_add(running_sum, ad * ad, ALL_ONES);
         MET_MAXIMUM:   if (ad > running_sum) running_sum = ad;
         MET_MANHATTAN: running_sum = clipped_add(running_sum, ad, DIST_MAX);
         MET_MINKOWSKI: running_sum = clipped_add(running_sum, power_term(ad), ALL_ONES);
         MET_CANBERRA: begin
            if (ax + ay > 0)
               running_sum = clipped_add(running_sum, (ad << 16) / (ax + ay), DIST_MAX);
         end
         default: ;
      endcase
      if (!b.last) return;
      case (metric_cfg)
         MET_EUCLID:    dist_value = int_sqrt(running_sum);
         MET_MAXIMUM, MET_MANHATTAN, MET_CANBERRA: dist_value = running_sum;
         MET_MINKOWSKI: dist_value = power_root(running_sum, clip);
         default:       dist_value = '0;
      endcase
      if (dist_value > DIST_MAX) begin
         dist_value = DIST_MAX;
         clip       = 1'b1;
      end
      res.distance  = dist_value[47:0];
      res.saturated = clip_seen | clip;
      expected_distances.push_back(res);
      running_sum = '0;
      clip_seen   = 1'b0;
   endfunction

   always @(posedge clock) begin
      if (csr_write_enable) begin
         if (csr_index == CSR_METRIC) metric_cfg = csr_write_data[2:0];
         else                         exponent_cfg = csr_write_data;
      end
   end

   // ---------------- driver ----------------
   int            burst_left = 4;
   int            gap_left = 0;
   logic          offer;
   pair_beat_type next_beat;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            fold_pair('{req_x_value, req_y_value, req_last_element});
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_pairs.size() != 0) begin
               next_beat = pending_pairs.pop_front();
               req_x_value      <= next_beat.x;
               req_y_value      <= next_beat.y;
               req_last_element <= next_beat.last;
               offer = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_valid <= offer;
      end
   end

   // ---------------- monitor ----------------
   int           stall_mode = 0;
   int           mode_left = 50;
   int           hold_left = 0;
   logic         hold_done = 1'b0;
   distance_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            distances_seen++;
            if (expected_distances.size() == 0) begin
               $error("unexpected distance beat: distance=%0h saturated=%0b",
                      rsp_distance, rsp_saturated);
               errors++;
            end else begin
               want = expected_distances.pop_front();
               if (rsp_distance !== want.distance) begin
                  $error("distance: expected %0h, got %0h", want.distance, rsp_distance);
                  errors++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b", want.saturated, rsp_saturated);
                  errors++;
               end
            end
         end
         // long hold-off once, so the block backs up onto its input
         if (!hold_done && distances_seen == 30) begin
            hold_done = 1'b1;
            hold_left = 1500;
         end
         if (--mode_left <= 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 200);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic send_pair(logic [31:0] x, logic [31:0] y, logic last);
      pending_pairs.push_back('{x, y, last});
      pairs_sent++;
   endtask

   task automatic wait_idle();
      while (pending_pairs.size() != 0 || req_valid || expected_distances.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3, 4:    return 32'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_exponent();
      case ($urandom_range(0, 7))
         0:       return P_MIN;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 255));
         3:       return 16'($urandom);
         default: return 16'($urandom_range(256, 1024));
      endcase
   endfunction

   initial begin
      logic [31:0] x;
      int          len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // euclidean at reset settings: squares of the widest difference saturate
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
      send_pair(32'h0000_0001, 32'h0000_0000, 1'b1);
      wait_idle();
      write_reg(CSR_METRIC, 16'(MET_MAXIMUM));
      send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_pair(32'h0000_0005, 32'hFFFF_FFFB, 1'b1);
      wait_idle();
      write_reg(CSR_METRIC, 16'(MET_MANHATTAN));
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_pair(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
      wait_idle();
      // canberra with a zero denominator term
      write_reg(CSR_METRIC, 16'(MET_CANBERRA));
      send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_pair(32'h0001_0000, 32'hFFFF_0000, 1'b0);
      send_pair(32'h0000_0003, 32'h0000_0001, 1'b1);
      wait_idle();
      // minkowski: exponent below one, huge exponent, zero sum
      write_reg(CSR_METRIC, 16'(MET_MINKOWSKI));
      write_reg(CSR_MINK_P, 16'd100);
      send_pair(32'h0001_0000, 32'h0000_0000, 1'b0);
      send_pair(32'h0002_0000, 32'h0000_0000, 1'b1);
      wait_idle();
      write_reg(CSR_MINK_P, 16'hFFFF);
      send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_pair(32'h0000_0001, 32'h0000_0000, 1'b1);
      wait_idle();
      write_reg(CSR_MINK_P, P_MIN);
      send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
      send_pair(32'h0003_8000, 32'hFFFE_0000, 1'b1);
      wait_idle();
      write_reg(CSR_METRIC, 16'(MET_SPARE_LO));
      send_pair(32'h0000_0001, 32'h0000_0002, 1'b1);
      wait_idle();
      write_reg(CSR_METRIC, 16'(MET_SPARE_HI));
      send_pair(32'h1234_5678, 32'h8765_4321, 1'b1);
      wait_idle();
      // metric switched between pairs of one vector
      write_reg(CSR_METRIC, 16'(MET_EUCLID));
      send_pair(32'h0003_0000, 32'h0000_0000, 1'b0);
      wait_idle();
      write_reg(CSR_METRIC, 16'(MET_MANHATTAN));
      send_pair(32'h0001_0000, 32'h0000_0000, 1'b1);
      wait_idle();

      while (pairs_sent < TARGET_PAIRS) begin
         if ($urandom_range(0, 9) == 0)
            write_reg(CSR_METRIC, 16'($urandom_range(0, 7)));
         else
            write_reg(CSR_METRIC, 16'($urandom_range(0, 4)));
         if ($urandom_range(0, 1)) write_reg(CSR_MINK_P, pick_exponent());
         repeat ($urandom_range(4, 14)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               x = pick_value();
               // equal elements now and then
               send_pair(x, ($urandom_range(0, 7) == 0) ? x : pick_value(), i == len - 1);
            end
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("PASS dense_vector_distance_unit");
      end else begin
         $display("FAIL dense_vector_distance_unit");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL dense_vector_distance_unit");
      $finish;
   end

endmodule
